[sv/npp_pkg.sv]
// ----------------------------------------------------------------------------
// npp_pkg
// Shared types, codes and character constants of the PGM/PPM stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package npp_pkg;

    // default sizes, handed to the top level parameters
    localparam int DIM_BITS_DEF   = 16;
    localparam int ACCUM_BITS_DEF = 32;

    // result queue depth and its pointer / count widths
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    // largest maxval and largest 8-bit sample
    localparam logic [16:0] MAXVAL_LIMIT = 17'd65535;
    localparam logic [7:0]  BYTE_MAX     = 8'd255;

    // characters of the file syntax
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // parser phase
    typedef enum logic [3:0] {
        PH_MAGIC0   = 4'd0,
        PH_MAGIC1   = 4'd1,
        PH_MAGICBAD = 4'd2,
        PH_WIDTH    = 4'd3,
        PH_HEIGHT   = 4'd4,
        PH_MAXVAL   = 4'd5,
        PH_RASTER   = 4'd6,
        PH_DONE     = 4'd7,
        PH_ERROR    = 4'd8
    } npp_phase_t;

    // result kind
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } npp_kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_UNSUPPORTED = 3'd1,
        ERR_TRUNC_MAGIC = 3'd2,
        ERR_INVALID     = 3'd3,
        ERR_OVERFLOW    = 3'd4,
        ERR_BAD_MAXVAL  = 3'd5,
        ERR_UNEXP_END   = 3'd6,
        ERR_TOO_LARGE   = 3'd7
    } npp_err_t;

    // one result item
    typedef struct packed {
        npp_kind_t   kind;
        npp_err_t    error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_value;
        logic        is_color;
        logic [15:0] sample_first;
        logic [15:0] sample_second;
        logic [15:0] sample_third;
        logic [15:0] column;
        logic [15:0] row;
        logic        last;
    } npp_result_t;

    // results pushed by the parser in one cycle
    typedef struct packed {
        logic first;
        logic second;
    } npp_push_t;

    // error result with all other fields zero
    function automatic npp_result_t npp_err_result(input npp_err_t code);
        npp_result_t r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/npp_stream_if.sv]
// ----------------------------------------------------------------------------
// npp_stream_if
// Valid/ready channels of the parser: file bytes in, result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface npp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface npp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        is_color;
    logic [15:0] sample_first;
    logic [15:0] sample_second;
    logic [15:0] sample_third;
    logic [15:0] column;
    logic [15:0] row;
    logic        last;

    modport source (
        output valid, output kind, output error_code, output image_width,
        output image_height, output max_value, output is_color, output sample_first,
        output sample_second, output sample_third, output column, output row,
        output last, input ready
    );
    modport sink (
        input valid, input kind, input error_code, input image_width,
        input image_height, input max_value, input is_color, input sample_first,
        input sample_second, input sample_third, input column, input row,
        input last, output ready
    );
endinterface

`default_nettype wire

[sv/npp_result_fifo.sv]
// ----------------------------------------------------------------------------
// npp_result_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module npp_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  npp_pkg::npp_push_t   push,
    input  npp_pkg::npp_result_t res_a,
    input  npp_pkg::npp_result_t res_b,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output npp_pkg::npp_result_t out_data
);
    import npp_pkg::*;

    npp_result_t          entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_PTR_W-1:0] wr_ptr_plus;
    logic [RES_CNT_W-1:0] push_n;
    logic                 pop;

    // head of queue drives the output
    assign out_valid   = (count_reg != '0);
    assign out_data    = entry_reg[rd_ptr_reg];
    assign pop         = out_valid && out_ready;
    assign room        = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign wr_ptr_plus = wr_ptr_reg + RES_PTR_W'(1);

    // pointer and fill count update
    always_comb
    begin
        push_n      = push.first ? (push.second ? RES_CNT_W'(2) : RES_CNT_W'(1)) : '0;
        wr_ptr_next = wr_ptr_reg + push_n[RES_PTR_W-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + RES_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - (pop ? RES_CNT_W'(1) : RES_CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            entry_reg[wr_ptr_reg] <= res_a;
        end
        if (push.first && push.second)
        begin
            entry_reg[wr_ptr_plus] <= res_b;
        end
    end

endmodule

`default_nettype wire

[sv/npp_parse_core.sv]
// ----------------------------------------------------------------------------
// npp_parse_core
// Byte register plus one-pass parser: magic, header numbers and raster.
// ----------------------------------------------------------------------------
`default_nettype none

module npp_parse_core #(
    parameter int DIM_BITS   = npp_pkg::DIM_BITS_DEF,
    parameter int ACCUM_BITS = npp_pkg::ACCUM_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  logic                 in_eos,
    output logic                 in_ready,
    input  logic                 room,
    output npp_pkg::npp_push_t   push,
    output npp_pkg::npp_result_t res_a,
    output npp_pkg::npp_result_t res_b
);
    import npp_pkg::*;

    localparam int MW = ACCUM_BITS + 4;
    localparam int WW = (ACCUM_BITS > DIM_BITS) ? ACCUM_BITS : DIM_BITS;
    localparam int OW = (DIM_BITS > 16) ? DIM_BITS : 16;

    // input register
    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_eos_reg;
    logic       fire;

    // parser state
    npp_phase_t            phase_reg, phase_next;
    logic [ACCUM_BITS-1:0] acc_reg, acc_next;
    logic                  digit_seen_reg, digit_seen_next;
    logic                  in_comment_reg, in_comment_next;
    logic                  color_reg, color_next;
    logic                  plain_reg, plain_next;
    logic                  wide_reg, wide_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [15:0]           maxval_reg, maxval_next;
    logic [DIM_BITS-1:0]   col_reg, col_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic [1:0]            chan_reg, chan_next;
    logic [15:0]           held_reg [2];
    logic [15:0]           held_next [2];
    logic [7:0]            high_reg, high_next;

    // byte classes
    logic [7:0] c;
    logic       eos;
    logic [7:0] digit_full;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_space;
    logic       is_magic;
    logic       hdr_scan;

    // number arithmetic
    logic [MW-1:0]       acc_mul;
    logic                acc_ovf;
    logic [WW-1:0]       acc_wide;
    logic [DIM_BITS-1:0] dim_val;
    logic                dim_big;
    logic                max_bad;

    // decoded events of this transaction
    logic        err_hit;
    npp_err_t    err_code;
    logic        tail_err;
    npp_err_t    tail_code;
    logic        hdr_emit;
    logic        take;
    logic [15:0] take_val;
    logic        num_done;
    logic        acc_step;
    logic        high_latch;
    logic        mode_set;
    logic        magic_p;
    logic        dim_store;

    // pixel bookkeeping
    logic                hold_chan;
    logic                px_emit;
    logic [DIM_BITS-1:0] col_inc;
    logic [DIM_BITS-1:0] row_inc;
    logic                wrap;
    logic                px_last;
    logic                hdr_last;
    logic                done_hit;
    logic                err_final;
    npp_err_t            final_code;
    logic [OW-1:0]       width_o, height_o, col_o, row_o;

    // input handshake: one byte held, freed when the queue has room
    assign fire     = hold_valid_reg && room;
    assign in_ready = !hold_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= in_byte;
            hold_eos_reg  <= in_eos;
        end
    end

    // byte classification
    assign c          = hold_byte_reg;
    assign eos        = hold_eos_reg;
    assign digit_full = c - CH_ZERO;
    assign digit      = digit_full[3:0];
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_magic   = (c == CH_TWO) || (c == CH_THREE) || (c == CH_FIVE) || (c == CH_SIX);
    assign hdr_scan   = in_comment_reg ? (c == CH_NL) : (c != CH_HASH);

    // decimal accumulate with exact overflow check
    assign acc_mul  = MW'({acc_reg, 3'b000}) + MW'({acc_reg, 1'b0}) + MW'(digit);
    assign acc_ovf  = (acc_mul[MW-1:ACCUM_BITS] != '0);
    assign acc_wide = WW'(acc_reg);
    assign dim_val  = acc_wide[DIM_BITS-1:0];
    assign dim_big  = ((acc_wide >> DIM_BITS) != '0);
    assign max_bad  = (acc_reg == '0) || (ACCUM_BITS'(acc_reg >> 16) != '0);

    // event decode per phase
    always_comb
    begin
        err_hit    = 1'b0;
        err_code   = ERR_NONE;
        tail_err   = 1'b0;
        tail_code  = ERR_INVALID;
        hdr_emit   = 1'b0;
        take       = 1'b0;
        take_val   = acc_reg[15:0];
        num_done   = 1'b0;
        acc_step   = 1'b0;
        high_latch = 1'b0;
        mode_set   = 1'b0;
        magic_p    = 1'b0;
        dim_store  = 1'b0;
        case (phase_reg)
            PH_MAGIC0:
            begin
                if (eos)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_TRUNC_MAGIC;
                end
                else
                begin
                    magic_p = (c == CH_P);
                end
            end
            PH_MAGIC1:
            begin
                err_hit  = eos || !is_magic;
                err_code = eos ? ERR_TRUNC_MAGIC : ERR_UNSUPPORTED;
                mode_set = !eos && is_magic;
            end
            PH_MAGICBAD:
            begin
                err_hit  = 1'b1;
                err_code = eos ? ERR_TRUNC_MAGIC : ERR_UNSUPPORTED;
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
            begin
                if (eos)
                begin
                    num_done = digit_seen_reg;
                    err_hit  = !digit_seen_reg;
                    err_code = ERR_INVALID;
                end
                else if (hdr_scan)
                begin
                    if (is_digit)
                    begin
                        err_hit  = acc_ovf;
                        err_code = ERR_OVERFLOW;
                        acc_step = !acc_ovf;
                    end
                    else if (is_space)
                    begin
                        num_done = digit_seen_reg;
                    end
                    else
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_INVALID;
                    end
                end
                // a finished number lands in its header field
                if (num_done)
                begin
                    if (phase_reg != PH_MAXVAL)
                    begin
                        if (dim_big)
                        begin
                            err_hit  = 1'b1;
                            err_code = ERR_TOO_LARGE;
                        end
                        else
                        begin
                            dim_store = 1'b1;
                            err_hit   = eos;
                            err_code  = ERR_INVALID;
                        end
                    end
                    else if (max_bad)
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_BAD_MAXVAL;
                    end
                    else
                    begin
                        hdr_emit  = 1'b1;
                        tail_err  = eos;
                        tail_code = plain_reg ? ERR_INVALID : ERR_UNEXP_END;
                    end
                end
            end
            PH_RASTER:
            begin
                if (plain_reg)
                begin
                    if (eos)
                    begin
                        take     = digit_seen_reg;
                        tail_err = digit_seen_reg;
                        err_hit  = !digit_seen_reg;
                        err_code = ERR_INVALID;
                    end
                    else if (is_digit)
                    begin
                        err_hit  = acc_ovf;
                        err_code = ERR_OVERFLOW;
                        acc_step = !acc_ovf;
                    end
                    else if (is_space)
                    begin
                        take = digit_seen_reg;
                    end
                    else
                    begin
                        err_hit  = 1'b1;
                        err_code = ERR_INVALID;
                    end
                    num_done = take;
                end
                else if (eos)
                begin
                    err_hit  = 1'b1;
                    err_code = ERR_UNEXP_END;
                end
                else if (wide_reg)
                begin
                    // digit_seen marks a held high byte
                    high_latch = !digit_seen_reg;
                    take       = digit_seen_reg;
                    num_done   = digit_seen_reg;
                    take_val   = {high_reg, c};
                end
                else
                begin
                    take     = 1'b1;
                    take_val = {8'h00, c};
                end
            end
            default:
            begin
                err_hit = 1'b0;
            end
        endcase
    end

    // pixel position and end of image
    assign hold_chan  = take && color_reg && (chan_reg != 2'd2);
    assign px_emit    = take && !hold_chan;
    assign col_inc    = col_reg + DIM_BITS'(1);
    assign row_inc    = row_reg + DIM_BITS'(1);
    assign wrap       = (col_inc == width_reg);
    assign px_last    = wrap && (row_inc == height_reg);
    assign hdr_last   = (width_reg == '0) || (height_reg == '0);
    assign done_hit   = (hdr_emit && hdr_last) || (px_emit && px_last);
    assign err_final  = err_hit || (tail_err && !done_hit);
    assign final_code = err_hit ? err_code : tail_code;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (eos)
            begin
                phase_next = PH_MAGIC0;
            end
            else if (err_final)
            begin
                phase_next = PH_ERROR;
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC0: phase_next = magic_p ? PH_MAGIC1 : PH_MAGICBAD;
                    PH_MAGIC1:
                    begin
                        if (mode_set)
                        begin
                            phase_next = PH_WIDTH;
                        end
                    end
                    PH_WIDTH:
                    begin
                        if (dim_store)
                        begin
                            phase_next = PH_HEIGHT;
                        end
                    end
                    PH_HEIGHT:
                    begin
                        if (dim_store)
                        begin
                            phase_next = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL:
                    begin
                        if (hdr_emit)
                        begin
                            phase_next = hdr_last ? PH_DONE : PH_RASTER;
                        end
                    end
                    PH_RASTER:
                    begin
                        if (px_emit && px_last)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // result items
    assign width_o  = OW'(width_reg);
    assign height_o = OW'(height_reg);
    assign col_o    = OW'(col_reg);
    assign row_o    = OW'(row_reg);

    always_comb
    begin
        push.first  = fire && (hdr_emit || px_emit || err_final);
        push.second = fire && (hdr_emit || px_emit) && err_final;
        res_b       = npp_err_result(final_code);
        res_a       = npp_err_result(final_code);
        if (hdr_emit || px_emit)
        begin
            res_a.kind         = hdr_emit ? KIND_HEADER : KIND_PIXEL;
            res_a.error_code   = ERR_NONE;
            res_a.image_width  = width_o[15:0];
            res_a.image_height = height_o[15:0];
            res_a.max_value    = hdr_emit ? acc_reg[15:0] : maxval_reg;
            res_a.is_color     = color_reg;
            res_a.last         = hdr_emit ? hdr_last : px_last;
        end
        if (px_emit)
        begin
            res_a.sample_first  = color_reg ? held_reg[0] : take_val;
            res_a.sample_second = color_reg ? held_reg[1] : 16'h0000;
            res_a.sample_third  = color_reg ? take_val : 16'h0000;
            res_a.column        = col_o[15:0];
            res_a.row           = row_o[15:0];
        end
    end

    // datapath next values
    always_comb
    begin
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        in_comment_next = in_comment_reg;
        color_next      = color_reg;
        plain_next      = plain_reg;
        wide_next       = wide_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        chan_next       = chan_reg;
        held_next[0]    = held_reg[0];
        held_next[1]    = held_reg[1];
        high_next       = high_reg;

        // number accumulator
        if (acc_step)
        begin
            acc_next        = acc_mul[ACCUM_BITS-1:0];
            digit_seen_next = 1'b1;
        end
        else if (num_done)
        begin
            acc_next        = '0;
            digit_seen_next = 1'b0;
        end
        if (high_latch)
        begin
            high_next       = c;
            digit_seen_next = 1'b1;
        end

        // comment skipping in the header
        if ((phase_reg == PH_WIDTH) || (phase_reg == PH_HEIGHT) || (phase_reg == PH_MAXVAL))
        begin
            in_comment_next = in_comment_reg ? (c != CH_NL) : (c == CH_HASH);
        end
        if (hdr_emit)
        begin
            in_comment_next = 1'b0;
        end

        // header fields
        if (mode_set)
        begin
            color_next = (c == CH_THREE) || (c == CH_SIX);
            plain_next = (c == CH_TWO) || (c == CH_THREE);
        end
        if (dim_store && (phase_reg == PH_WIDTH))
        begin
            width_next = dim_val;
        end
        if (dim_store && (phase_reg == PH_HEIGHT))
        begin
            height_next = dim_val;
        end
        if (hdr_emit)
        begin
            maxval_next = acc_reg[15:0];
            wide_next   = (acc_reg[15:0] > 16'(BYTE_MAX));
        end

        // samples and raster position
        if (hold_chan)
        begin
            held_next[chan_reg[0]] = take_val;
            chan_next              = chan_reg + 2'd1;
        end
        else if (px_emit)
        begin
            chan_next = 2'd0;
            col_next  = wrap ? '0 : col_inc;
            row_next  = wrap ? row_inc : row_reg;
        end
    end

    // state registers; end of stream returns all to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC0;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            in_comment_reg <= 1'b0;
            color_reg      <= 1'b0;
            plain_reg      <= 1'b0;
            wide_reg       <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            chan_reg       <= '0;
            held_reg[0]    <= '0;
            held_reg[1]    <= '0;
            high_reg       <= '0;
        end
        else if (fire && eos)
        begin
            phase_reg      <= phase_next;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            in_comment_reg <= 1'b0;
            color_reg      <= 1'b0;
            plain_reg      <= 1'b0;
            wide_reg       <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            chan_reg       <= '0;
            held_reg[0]    <= '0;
            held_reg[1]    <= '0;
            high_reg       <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            digit_seen_reg <= digit_seen_next;
            in_comment_reg <= in_comment_next;
            color_reg      <= color_next;
            plain_reg      <= plain_next;
            wide_reg       <= wide_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            chan_reg       <= chan_next;
            held_reg[0]    <= held_next[0];
            held_reg[1]    <= held_next[1];
            high_reg       <= high_next;
        end
    end

endmodule

`default_nettype wire

[sv/netpbm_pgm_ppm_stream_parser_top.sv]
// Flow: an accepted byte waits in the byte register until the queue has room, is
//   parsed there, and its results are then taken from the head of the result queue.
// Throughput: one byte per cycle; the result queue limits the rate only when
//   an end-of-stream transaction yields two results or the sink stalls.
// Reset: rst_n clears the parser, byte register and result queue at once.
// ----------------------------------------------------------------------------
// netpbm_pgm_ppm_stream_parser_top
// PGM/PPM byte stream parser: header and pixel results over valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module netpbm_pgm_ppm_stream_parser_top #(
    parameter int DIM_BITS   = npp_pkg::DIM_BITS_DEF,
    parameter int ACCUM_BITS = npp_pkg::ACCUM_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    npp_byte_if.sink     stream,
    npp_result_if.source result
);
    import npp_pkg::*;

    npp_push_t   push;
    npp_result_t res_a;
    npp_result_t res_b;
    npp_result_t head;
    logic        room;

    // parser with its byte register
    npp_parse_core #(
        .DIM_BITS   (DIM_BITS),
        .ACCUM_BITS (ACCUM_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_byte  (stream.data_byte),
        .in_eos   (stream.end_of_stream),
        .in_ready (stream.ready),
        .room     (room),
        .push     (push),
        .res_a    (res_a),
        .res_b    (res_b)
    );

    // result queue
    npp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b),
        .room      (room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (head)
    );

    // result channel payload
    assign result.kind          = head.kind;
    assign result.error_code    = head.error_code;
    assign result.image_width   = head.image_width;
    assign result.image_height  = head.image_height;
    assign result.max_value     = head.max_value;
    assign result.is_color      = head.is_color;
    assign result.sample_first  = head.sample_first;
    assign result.sample_second = head.sample_second;
    assign result.sample_third  = head.sample_third;
    assign result.column        = head.column;
    assign result.row           = head.row;
    assign result.last          = head.last;

endmodule

`default_nettype wire

[sv/npp_checker.sv]
// ----------------------------------------------------------------------------
// npp_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module npp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [1:0]  kind,
    input logic [2:0]  error_code,
    input logic [15:0] image_width,
    input logic [15:0] image_height,
    input logic [15:0] max_value,
    input logic        is_color,
    input logic [15:0] sample_first,
    input logic [15:0] sample_second,
    input logic [15:0] sample_third,
    input logic [15:0] column,
    input logic [15:0] row,
    input logic        last
);
    import npp_pkg::*;

    // error transactions carry a code and nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_ERROR) |->
            (error_code != ERR_NONE) && (image_width == 16'h0) && (image_height == 16'h0)
            && (max_value == 16'h0) && !is_color && (sample_first == 16'h0)
            && (column == 16'h0) && (row == 16'h0) && !last)
        else $error("error result with nonzero payload");

    // header transactions: valid maxval, no samples, no position
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_HEADER) |->
            (error_code == ERR_NONE) && (max_value != 16'h0) && (sample_first == 16'h0)
            && (sample_second == 16'h0) && (sample_third == 16'h0)
            && (column == 16'h0) && (row == 16'h0))
        else $error("malformed header result");

    // gray pixels leave green and blue at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (kind == KIND_PIXEL) |->
            (error_code == ERR_NONE) && (max_value != 16'h0)
            && (is_color || ((sample_second == 16'h0) && (sample_third == 16'h0))))
        else $error("malformed pixel result");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(kind) && $stable(error_code) && $stable(sample_first)
            && $stable(column) && $stable(row) && $stable(last))
        else $error("stalled result changed");

endmodule

bind netpbm_pgm_ppm_stream_parser_top npp_checker u_npp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .kind          (result.kind),
    .error_code    (result.error_code),
    .image_width   (result.image_width),
    .image_height  (result.image_height),
    .max_value     (result.max_value),
    .is_color      (result.is_color),
    .sample_first  (result.sample_first),
    .sample_second (result.sample_second),
    .sample_third  (result.sample_third),
    .column        (result.column),
    .row           (result.row),
    .last          (result.last)
);

`default_nettype wire

[dv/npp_parse_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npp_parse_monitor
// Watches the byte and result channels of the PGM/PPM parser. Every accepted
// byte runs through a local model of the parser, and the results it predicts
// are compared field by field with the result transactions, in order.
// ----------------------------------------------------------------------------
module npp_parse_monitor #(
    parameter int DIM_BITS   = npp_pkg::DIM_BITS_DEF,
    parameter int ACCUM_BITS = npp_pkg::ACCUM_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    npp_byte_if   stream,
    npp_result_if result,
    output int    fail_count,
    output int    pending,
    output int    checked_count
);
    import npp_pkg::*;

    localparam logic [63:0] DIM_LIMIT = (64'd1 << DIM_BITS) - 64'd1;
    localparam logic [63:0] ACC_LIMIT = (64'd1 << ACCUM_BITS) - 64'd1;
    localparam logic [7:0]  CH_VT     = 8'h0B;
    localparam logic [7:0]  CH_FF     = 8'h0C;

    typedef enum logic [1:0] {
        NUM_MORE,
        NUM_DONE,
        NUM_BAD
    } num_status_t;

    // parser state of the model
    npp_phase_t  phase_q;
    logic [31:0] acc_q;
    logic        digits_q;
    logic        comment_q;
    logic        color_q;
    logic        plain_q;
    logic        wide_q;
    logic [31:0] width_q;
    logic [31:0] height_q;
    logic [31:0] maxval_q;
    logic [31:0] col_q;
    logic [31:0] row_q;
    logic [1:0]  chan_q;
    logic [15:0] held_q [2];
    logic [7:0]  hi_q;

    // results predicted for the current byte, and all still owed by the dut
    int          step_n;
    npp_result_t expected_results[$];

    function automatic void clear_parser();
        phase_q   = PH_MAGIC0;
        acc_q     = '0;
        digits_q  = 1'b0;
        comment_q = 1'b0;
        color_q   = 1'b0;
        plain_q   = 1'b0;
        wide_q    = 1'b0;
        width_q   = '0;
        height_q  = '0;
        maxval_q  = '0;
        col_q     = '0;
        row_q     = '0;
        chan_q    = '0;
        held_q[0] = '0;
        held_q[1] = '0;
        hi_q      = '0;
    endfunction

    // at most two results per byte; header fields only on header and pixel
    function automatic void push_result(npp_kind_t k, npp_err_t e, logic [15:0] s0,
                                        logic [15:0] s1, logic [15:0] s2,
                                        logic [31:0] c, logic [31:0] r, logic l);
        npp_result_t res;
        if (step_n >= 2)
            return;
        res            = '0;
        res.kind       = k;
        res.error_code = e;
        if (k != KIND_ERROR)
        begin
            res.image_width  = width_q[15:0];
            res.image_height = height_q[15:0];
            res.max_value    = maxval_q[15:0];
            res.is_color     = color_q;
        end
        res.sample_first  = s0;
        res.sample_second = s1;
        res.sample_third  = s2;
        res.column        = c[15:0];
        res.row           = r[15:0];
        res.last          = l;
        expected_results.push_back(res);
        step_n++;
    endfunction

    function automatic void raise_error(npp_err_t e);
        push_result(KIND_ERROR, e, '0, '0, '0, '0, '0, 1'b0);
        phase_q = PH_ERROR;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_digit_char(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // decimal number scanner shared by header and plain raster
    function automatic num_status_t scan_char(input logic [7:0] c, input logic eof,
                                              output logic [31:0] val,
                                              output npp_err_t code);
        logic [63:0] v;
        val  = '0;
        code = ERR_NONE;
        if (!eof && is_digit_char(c))
        begin
            v = {32'd0, acc_q} * 64'd10 + 64'(c - CH_ZERO);
            if (v > ACC_LIMIT)
            begin
                code = ERR_OVERFLOW;
                return NUM_BAD;
            end
            acc_q    = v[31:0];
            digits_q = 1'b1;
            return NUM_MORE;
        end
        if (!digits_q)
        begin
            if (!eof && is_blank(c))
                return NUM_MORE;
            code = ERR_INVALID;
            return NUM_BAD;
        end
        if (eof || is_blank(c))
        begin
            val      = acc_q;
            acc_q    = '0;
            digits_q = 1'b0;
            return NUM_DONE;
        end
        code = ERR_INVALID;
        return NUM_BAD;
    endfunction

    // collect channels, emit a pixel once the set is complete
    function automatic void take_sample(logic [31:0] v);
        logic [15:0] s;
        logic [31:0] c0;
        logic [31:0] r0;
        logic        fin;
        s  = v[15:0];
        c0 = col_q;
        r0 = row_q;
        if (color_q && chan_q < 2'd2)
        begin
            held_q[chan_q[0]] = s;
            chan_q++;
            return;
        end
        chan_q = '0;
        col_q++;
        if (col_q >= width_q)
        begin
            col_q = '0;
            row_q++;
        end
        fin = (row_q >= height_q);
        if (color_q)
            push_result(KIND_PIXEL, ERR_NONE, held_q[0], held_q[1], s, c0, r0, fin);
        else
            push_result(KIND_PIXEL, ERR_NONE, s, '0, '0, c0, r0, fin);
        if (fin)
            phase_q = PH_DONE;
    endfunction

    // width, height and maxval with comments skipped
    function automatic void feed_header(logic [7:0] c, logic eof);
        logic [31:0] v;
        npp_err_t    e;
        num_status_t st;
        logic        empty;
        if (comment_q)
        begin
            if (eof || c == CH_NL)
                comment_q = 1'b0;
            else
                return;
        end
        else if (!eof && c == CH_HASH)
        begin
            comment_q = 1'b1;
            return;
        end
        st = scan_char(c, eof, v, e);
        if (st == NUM_MORE)
            return;
        if (st == NUM_BAD)
        begin
            raise_error(e);
            return;
        end
        case (phase_q)
            PH_WIDTH:
            begin
                if ({32'd0, v} > DIM_LIMIT)
                    raise_error(ERR_TOO_LARGE);
                else
                begin
                    width_q = v;
                    phase_q = PH_HEIGHT;
                end
            end
            PH_HEIGHT:
            begin
                if ({32'd0, v} > DIM_LIMIT)
                    raise_error(ERR_TOO_LARGE);
                else
                begin
                    height_q = v;
                    phase_q  = PH_MAXVAL;
                end
            end
            default:
            begin
                if (v == 32'd0 || v > MAXVAL_LIMIT)
                    raise_error(ERR_BAD_MAXVAL);
                else
                begin
                    maxval_q  = v;
                    wide_q    = (v > BYTE_MAX);
                    comment_q = 1'b0;
                    empty     = (width_q == 32'd0 || height_q == 32'd0);
                    push_result(KIND_HEADER, ERR_NONE, '0, '0, '0, '0, '0, empty);
                    if (empty)
                        phase_q = PH_DONE;
                    else
                        phase_q = PH_RASTER;
                end
            end
        endcase
    endfunction

    // plain decimal, 8-bit or 16-bit big-endian samples
    function automatic void feed_raster(logic [7:0] c, logic eof);
        logic [31:0] v;
        npp_err_t    e;
        num_status_t st;
        if (plain_q)
        begin
            st = scan_char(c, eof, v, e);
            if (st == NUM_MORE)
                return;
            if (st == NUM_BAD)
            begin
                raise_error(e);
                return;
            end
            take_sample(v);
            return;
        end
        if (eof)
        begin
            raise_error(ERR_UNEXP_END);
            return;
        end
        if (wide_q)
        begin
            if (!digits_q)
            begin
                hi_q     = c;
                digits_q = 1'b1;
                return;
            end
            digits_q = 1'b0;
            take_sample({16'd0, hi_q, c});
            return;
        end
        take_sample({24'd0, c});
    endfunction

    function automatic void feed(logic [7:0] c, logic eof);
        case (phase_q)
            PH_MAGIC0:
            begin
                if (eof)
                    raise_error(ERR_TRUNC_MAGIC);
                else if (c == CH_P)
                    phase_q = PH_MAGIC1;
                else
                    phase_q = PH_MAGICBAD;
            end
            PH_MAGIC1:
            begin
                if (eof)
                    raise_error(ERR_TRUNC_MAGIC);
                else if (c == CH_TWO || c == CH_THREE || c == CH_FIVE || c == CH_SIX)
                begin
                    color_q = (c == CH_THREE || c == CH_SIX);
                    plain_q = (c == CH_TWO || c == CH_THREE);
                    phase_q = PH_WIDTH;
                end
                else
                    raise_error(ERR_UNSUPPORTED);
            end
            PH_MAGICBAD:
            begin
                if (eof)
                    raise_error(ERR_TRUNC_MAGIC);
                else
                    raise_error(ERR_UNSUPPORTED);
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                feed_header(c, eof);
            PH_RASTER:
                feed_raster(c, eof);
            default:
                ;
        endcase
    endfunction

    // one accepted byte; end of stream flushes open numbers, then restarts
    function automatic void parse_byte(logic [7:0] c, logic eof);
        step_n = 0;
        if (!eof)
            feed(c, 1'b0);
        else
        begin
            feed(8'd0, 1'b1);
            for (int k = 0; k < 4 && phase_q >= PH_WIDTH && phase_q <= PH_RASTER; k++)
                feed(8'd0, 1'b1);
            clear_parser();
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v,
                                        logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        checked_count = 0;
        step_n        = 0;
        clear_parser();
    end

    // result transactions first: a byte taken now cannot yield a result now
    always @(posedge clk)
    begin
        npp_result_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                checked_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none expected, kind %0d", result.kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, result.kind);
                    check_field("error_code", want.error_code, result.error_code);
                    check_field("image_width", want.image_width, result.image_width);
                    check_field("image_height", want.image_height, result.image_height);
                    check_field("max_value", want.max_value, result.max_value);
                    check_field("is_color", want.is_color, result.is_color);
                    check_field("sample_first", want.sample_first, result.sample_first);
                    check_field("sample_second", want.sample_second, result.sample_second);
                    check_field("sample_third", want.sample_third, result.sample_third);
                    check_field("column", want.column, result.column);
                    check_field("row", want.row, result.row);
                    check_field("last", want.last, result.last);
                end
            end
            if (stream.valid && stream.ready)
                parse_byte(stream.data_byte, stream.end_of_stream);
        end
        pending = expected_results.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives PGM/PPM files byte by byte into the stream parser: a few short
// directed files, then random gray/color files in plain, 8-bit and 16-bit
// form, mostly well formed, some with bad magic, oversized or overflowing
// numbers, bad maxval, truncation or corrupted bytes. Both channels idle at
// random; the monitor checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import npp_pkg::*;

    localparam int          BYTE_TARGET  = 1100;
    localparam int          QUIET_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [7:0]  CH_VT        = 8'h0B;
    localparam logic [7:0]  CH_FF        = 8'h0C;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked_count;
    int   bytes_sent   = 0;
    int   files_sent   = 0;
    int   quiet_cycles = 0;
    int   src_burst    = 0;
    int   snk_burst    = 0;

    // file under construction: {end_of_stream, data_byte}
    logic [8:0] file_q[$];

    npp_byte_if   byte_ch ();
    npp_result_if result_ch ();

    netpbm_pgm_ppm_stream_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch),
        .result (result_ch)
    );

    npp_parse_monitor parse_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .stream        (byte_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // clock
    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // random wait drawn from 0..5, with occasional stretches of no waiting
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            burst = $urandom_range(8, 40);
        return $urandom_range(0, 5);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        file_q.push_back({1'b0, b});
    endfunction

    function automatic void put_eof();
        file_q.push_back({1'b1, 8'($urandom)});
    endfunction

    function automatic void put_num(longint unsigned v, int zeros);
        logic [7:0] digits[$];
        repeat (zeros) put_byte(CH_ZERO);
        do
        begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        foreach (digits[i])
            put_byte(digits[i]);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // separator of up to max_n blanks or comments
    function automatic void put_gap(bit comments, int max_n);
        logic [7:0] b;
        repeat ($urandom_range(1, max_n))
        begin
            if (comments && $urandom_range(0, 4) == 0)
            begin
                put_byte(CH_HASH);
                repeat ($urandom_range(0, 4))
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_NL);
                    put_byte(b);
                end
                put_byte(CH_NL);
            end
            else
                put_byte(pick_blank());
        end
    endfunction

    // numbers past the dimension limit, past the accumulator, or both
    function automatic longint unsigned pick_huge();
        case ($urandom_range(0, 3))
            0: return 64'd65536;
            1: return 64'd4294967295;
            2: return 64'd4294967296;
            default: return 64'd99999999999;
        endcase
    endfunction

    function automatic int pick_zeros();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    // one random file, ending in an end-of-stream transaction
    function automatic void build_file();
        int              mode;
        int              w;
        int              h;
        int              samples;
        logic [7:0]      fmt;
        logic            color;
        logic            plain;
        longint unsigned wv;
        longint unsigned hv;
        longint unsigned mv;
        longint unsigned sv;
        mode = $urandom_range(0, 19);
        case ($urandom_range(0, 3))
            0: fmt = CH_TWO;
            1: fmt = CH_THREE;
            2: fmt = CH_FIVE;
            default: fmt = CH_SIX;
        endcase
        color = (fmt == CH_THREE || fmt == CH_SIX);
        plain = (fmt == CH_TWO || fmt == CH_THREE);

        // bad magic, then a few bytes that are ignored
        if (mode == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                put_byte(CH_P);
            else
                put_byte(8'($urandom));
            put_byte(8'($urandom));
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
            put_eof();
            return;
        end

        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        case ($urandom_range(0, 5))
            0: mv = 1;
            1: mv = 255;
            2: mv = 256;
            3: mv = 65535;
            4: mv = $urandom_range(2, 254);
            default: mv = $urandom_range(257, 65534);
        endcase
        wv = w;
        hv = h;
        case (mode)
            1: wv = pick_huge();
            2: hv = pick_huge();
            3:
            begin
                case ($urandom_range(0, 3))
                    0: mv = 0;
                    1: mv = 65536;
                    2: mv = 64'd4294967295;
                    default: mv = 64'd4294967296;
                endcase
            end
            4:
            begin
                // largest dimension with nothing to follow
                if ($urandom_range(0, 1) == 0)
                begin
                    wv = 65535;
                    hv = 0;
                end
                else
                begin
                    wv = 0;
                    hv = 65535;
                end
            end
            default:
                ;
        endcase

        // header
        put_byte(CH_P);
        put_byte(fmt);
        put_gap(1'b1, 3);
        put_num(wv, pick_zeros());
        put_gap(1'b1, 3);
        put_num(hv, pick_zeros());
        put_gap(1'b1, 3);
        put_num(mv, pick_zeros());
        put_gap(1'b1, 1);

        // raster
        if (mode >= 1 && mode <= 3)
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        else if (mode != 4)
        begin
            samples = w * h * (color ? 3 : 1);
            for (int i = 0; i < samples; i++)
            begin
                if (plain)
                begin
                    if ($urandom_range(0, 63) == 0)
                        sv = pick_huge();
                    else if ($urandom_range(0, 7) == 0)
                        sv = $urandom_range(0, 99999);
                    else
                        sv = $urandom_range(0, int'(mv));
                    put_num(sv, pick_zeros());
                    if (i != samples - 1 || $urandom_range(0, 1) == 0)
                        put_gap(1'b0, 2);
                end
                else
                begin
                    if (mv > BYTE_MAX)
                        put_byte(8'($urandom));
                    put_byte(8'($urandom));
                end
            end
        end

        // broken files: cut short, one byte hit, or junk after the end
        case (mode)
            5:
            begin
                samples = $urandom_range(0, file_q.size());
                while (file_q.size() > samples)
                    void'(file_q.pop_back());
            end
            6:
                file_q[$urandom_range(0, file_q.size() - 1)] = {1'b0, 8'($urandom)};
            7:
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            default:
                ;
        endcase
        put_eof();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = draw_wait(src_burst);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        foreach (file_q[i])
            send_byte(file_q[i][7:0], file_q[i][8]);
        file_q.delete();
        files_sent++;
    endtask

    // result sink with random stalls
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(snk_burst);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            @(negedge clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = 8'd0;
        byte_ch.end_of_stream = 1'b0;
        rst_n                 = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // end of stream before any byte: truncated magic
        put_eof();
        send_file();
        // end of stream after the first magic byte
        put_byte(CH_P);
        put_eof();
        send_file();
        // wrong first byte, then end of stream
        put_byte(8'hFF);
        put_eof();
        send_file();
        // unsupported magic
        put_byte(CH_P);
        put_byte(8'h37);
        put_eof();
        send_file();
        // smallest binary gray image
        put_byte(CH_P);
        put_byte(CH_FIVE);
        put_byte(CH_SPACE);
        put_num(1, 0);
        put_byte(CH_SPACE);
        put_num(1, 0);
        put_byte(CH_SPACE);
        put_num(255, 0);
        put_byte(CH_NL);
        put_byte(8'h00);
        put_eof();
        send_file();
        // end of stream where the width must start
        put_byte(CH_P);
        put_byte(CH_TWO);
        put_byte(CH_NL);
        put_eof();
        send_file();

        while (bytes_sent < BYTE_TARGET)
        begin
            build_file();
            send_file();
        end
        byte_ch.valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d bytes in %0d files, %0d result transactions checked",
                 bytes_sent, files_sent, checked_count);
        $display("files mixed gray/color, plain/8-bit/16-bit rasters, broken headers");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
